@@ sv/pkt_line_sideband_deframer_core_defines.svh @@
// Assertion macros used by the deframer checker.
`ifndef PKT_LINE_SIDEBAND_DEFRAMER_CORE_DEFINES_SVH
`define PKT_LINE_SIDEBAND_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PLD_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PLD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/pld_pkg.sv @@
// Shared types, codes and helpers for the packet-line sideband deframer.
package pld_pkg;

  // Default number of hex digits in a line header
  localparam int HEADER_DIGITS_DEF = 4;

  // Widths of the configuration registers
  localparam int MAX_LEN_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD_LEN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_DEMUX_EN = 1'd1;

  // Register reset values
  localparam logic [MAX_LEN_W-1:0] MAX_PAYLOAD_LEN_RST = 16'd65520;
  localparam logic BAND_DEMUX_EN_RST = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_MSG = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_BAD_HEX = 3'd1;
  localparam logic [2:0] ERR_BAD_LEN = 3'd2;
  localparam logic [2:0] ERR_HUNG_UP = 3'd3;
  localparam logic [2:0] ERR_BAD_BAND = 3'd4;

  // Band numbers
  localparam logic [7:0] BAND_DATA = 8'd1;
  localparam logic [7:0] BAND_MSG = 8'd2;

  // Header value reserved for the flush marker besides zero; also the header size
  localparam int HDR_BYTES = 4;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } pld_item_t;

  // One result transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] error_code;
  } pld_result_t;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ sv/pld_in_reg.sv @@
// Input register stage of the deframer.
module pld_in_reg
  import pld_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pld_item_t in_item,
  input  logic      advance,
  output logic      s1_valid,
  output pld_item_t s1_item
);

  logic      valid_r;
  pld_item_t item_r;

  // Take a new transaction whenever the stage is empty or moving on
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item = item_r;

endmodule

@@ sv/pld_parser.sv @@
// Line parser: header decode, band select, payload count and config registers.
module pld_parser
  import pld_pkg::*;
#(
  parameter int HEADER_DIGITS = HEADER_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   fire,
  input  pld_item_t              item,
  output logic                   res_valid,
  output pld_result_t            res
);

  localparam int LW = 4 * HEADER_DIGITS;
  localparam int CW = (HEADER_DIGITS > 1) ? $clog2(HEADER_DIGITS) : 1;
  localparam int CMPW = (LW > MAX_LEN_W) ? LW : MAX_LEN_W;
  localparam logic [CW-1:0] LAST_DIGIT = CW'(HEADER_DIGITS - 1);

  // Parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BAND = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_HALT = 2'd3;

  logic [MAX_LEN_W-1:0] max_len_r;
  logic                 demux_en_r;
  logic [1:0]           phase_r, phase_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [LW-1:0]        acc_r, acc_nxt;
  logic [MAX_LEN_W-1:0] left_r, left_nxt;
  logic                 msg_r, msg_nxt;

  logic [4:0]           hex;
  logic [LW-1:0]        acc_sh;
  logic [CMPW-1:0]      plen;
  logic [MAX_LEN_W-1:0] left_dec;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_PAYLOAD_LEN_RST;
      demux_en_r <= BAND_DEMUX_EN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MAX_PAYLOAD_LEN: max_len_r <= cfg_data[MAX_LEN_W-1:0];
        REG_BAND_DEMUX_EN:   demux_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Shared datapath terms
  assign hex = hex_decode(item.data_byte);
  assign acc_sh = {acc_r[LW-5:0], hex[3:0]};
  assign plen = CMPW'(acc_sh) - CMPW'(HDR_BYTES);
  assign left_dec = left_r - MAX_LEN_W'(1);

  // Next state and result for one transaction
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    left_nxt = left_r;
    msg_nxt = msg_r;
    res_valid = 1'b0;
    res = '0;
    if (fire && (phase_r != PH_HALT)) begin
      if (item.stream_end) begin
        res_valid = 1'b1;
        res.kind = KIND_ERR;
        res.error_code = ERR_HUNG_UP;
        phase_nxt = PH_HALT;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (!hex[4]) begin
              res_valid = 1'b1;
              res.kind = KIND_ERR;
              res.error_code = ERR_BAD_HEX;
              phase_nxt = PH_HALT;
            end else if (cnt_r != LAST_DIGIT) begin
              cnt_nxt = cnt_r + CW'(1);
              acc_nxt = acc_sh;
            end else begin
              cnt_nxt = '0;
              acc_nxt = '0;
              if ((acc_sh == '0) || (acc_sh == LW'(HDR_BYTES))) begin
                res_valid = 1'b1;
                res.kind = KIND_FLUSH;
              end else if ((acc_sh < LW'(HDR_BYTES)) || (plen >= CMPW'(max_len_r))) begin
                res_valid = 1'b1;
                res.kind = KIND_ERR;
                res.error_code = ERR_BAD_LEN;
                phase_nxt = PH_HALT;
              end else begin
                left_nxt = plen[MAX_LEN_W-1:0];
                msg_nxt = 1'b0;
                phase_nxt = demux_en_r ? PH_BAND : PH_PAYLOAD;
              end
            end
          end
          PH_BAND: begin
            left_nxt = left_dec;
            if ((item.data_byte != BAND_DATA) && (item.data_byte != BAND_MSG)) begin
              res_valid = 1'b1;
              res.kind = KIND_ERR;
              res.error_code = ERR_BAD_BAND;
              phase_nxt = PH_HALT;
            end else begin
              msg_nxt = (item.data_byte == BAND_MSG);
              if (left_dec == '0) begin
                // band byte only: nothing to emit
                phase_nxt = (item.data_byte == BAND_MSG) ? PH_HALT : PH_HEADER;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            left_nxt = left_dec;
            res_valid = 1'b1;
            res.kind = msg_r ? KIND_MSG : KIND_DATA;
            res.out_byte = item.data_byte;
            res.last = (left_dec == '0);
            if (left_dec == '0) begin
              phase_nxt = msg_r ? PH_HALT : PH_HEADER;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r <= '0;
      acc_r <= '0;
      left_r <= '0;
      msg_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
      left_r <= left_nxt;
      msg_r <= msg_nxt;
    end
  end

endmodule

@@ sv/pld_out_reg.sv @@
// Result register stage of the deframer.
module pld_out_reg
  import pld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  logic        res_valid,
  input  pld_result_t res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output pld_result_t out_res
);

  logic        valid_r;
  pld_result_t res_r;

  // Register is free when empty or being drained this cycle
  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res = res_r;

endmodule

@@ sv/pkt_line_sideband_deframer_core.sv @@
// Packet-line deframer with sideband demux: usage
// Input channel (in_valid/in_ready): one raw byte per transaction, or a
//   stream_end marker. Headers are hex length digits, payloads follow.
// Result channel (out_valid/out_ready): data bytes, remote message bytes,
//   flush markers and errors; at most one result per input transaction.
// Config port: cfg_wr_en writes cfg_data to register cfg_index (0 is the
//   max payload length, 1 the band demux enable); write only while idle.
// Path: an accepted input transaction goes through the input register, the
//   parser and then the result register before its result is on out_*.
// Throughput: one byte per cycle unless a held result stalls on out_ready;
//   the parser's next state is combinational, so the input and result
//   registers each pass one transaction per clock.
// Stall: when out_ready is low the result register holds, the input
//   register fills, and in_ready drops only once both are occupied.
// Reset (rst_n low, synchronous): both registers empty, parser waits for a
//   header, registers return to 65520 and demux on. After an error, or at
//   the end of a remote message, the block ignores input until reset.
module pkt_line_sideband_deframer_core
  import pld_pkg::*;
#(
  parameter int HEADER_DIGITS = HEADER_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_stream_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic [2:0]             out_error_code,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pld_item_t   in_item;
  pld_item_t   s1_item;
  logic        s1_valid;
  logic        advance;
  logic        res_valid;
  pld_result_t res;
  pld_result_t out_res;

  assign in_item.data_byte = in_data_byte;
  assign in_item.stream_end = in_stream_end;

  // Input register
  pld_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Parser
  pld_parser #(
    .HEADER_DIGITS (HEADER_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (s1_valid && advance),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  pld_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind = out_res.kind;
  assign out_byte = out_res.out_byte;
  assign out_last = out_res.last;
  assign out_error_code = out_res.error_code;

endmodule

@@ sv/pld_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
`include "pkt_line_sideband_deframer_core_defines.svh"

module pld_checker
  import pld_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic [2:0] out_error_code
);

  // A stalled result holds
  `PLD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_error_code),
    "stalled result changed")

  // Error code only rides on error results
  `PLD_ASSERT_NOW(a_err_code, out_valid && (out_kind != KIND_ERR),
    out_error_code == ERR_NONE, "error code on a non-error result")

  // Flush and error results carry no byte and no last flag
  `PLD_ASSERT_NOW(a_no_byte, out_valid && ((out_kind == KIND_FLUSH) || (out_kind == KIND_ERR)),
    (out_byte == 8'd0) && !out_last, "byte or last on a flush or error result")

  // Nothing follows an error
  `PLD_ASSERT_NEXT(a_halt, out_valid && out_ready && (out_kind == KIND_ERR),
    !out_valid, "result after an error")

  // Empty result register never blocks the input
  `PLD_ASSERT_NOW(a_ready, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind pkt_line_sideband_deframer_core pld_checker u_pld_checker (.*);
